// ===== rtl/core/cic_pkg.sv =====
package cic_pkg;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_ACK   = 2'd2;

  // initialization sequence steps
  localparam logic [1:0] STEP_READY = 2'd0;
  localparam logic [1:0] STEP_ICW2  = 2'd1;
  localparam logic [1:0] STEP_ICW3  = 2'd2;
  localparam logic [1:0] STEP_ICW4  = 2'd3;

  // command and data bits
  localparam logic [7:0] ICW1_START = 8'h10;
  localparam logic [7:0] ICW1_NEED4 = 8'h01;
  localparam logic [7:0] ICW1_LTIM  = 8'h08;
  localparam logic [7:0] OCW3_MARK  = 8'h08;
  localparam logic [7:0] OCW3_RR    = 8'h02;
  localparam logic [7:0] OCW3_RIS   = 8'h01;
  localparam logic [7:0] OCW2_EOI   = 8'h20;
  localparam logic [7:0] OCW2_SPEC  = 8'h40;
  localparam logic [7:0] ICW4_AEOI  = 8'h02;

  // mode flag bit positions
  localparam int FLAG_LEVEL = 0;
  localparam int FLAG_NEED4 = 1;
  localparam int FLAG_AEOI  = 2;

  // master line that carries the slave's interrupt output
  localparam int CASCADE_LINE = 2;

  typedef struct packed {
    logic       en;     // process one item this cycle
    logic       wr;     // bus write to this chip
    logic       port;   // 0 command, 1 data
    logic [7:0] data;
    logic       grant;  // acknowledge this chip's best line
  } cic_op_t;

  typedef struct packed {
    logic       int_s;      // interrupt output after sampling, before the access
    logic       int_after;  // interrupt output after the access
    logic       init_after; // in init sequence after the access
    logic       cas_hit;    // best line has its cascade bit set
    logic [7:0] rd_data;
    logic [7:0] vector;
  } cic_stat_t;

endpackage

// ===== rtl/core/cic_if.sv =====
interface cic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        chip;
  logic        port_sel;
  logic [7:0]  write_data;
  logic [15:0] request_lines;

  modport source (output valid, mode, chip, port_sel, write_data, request_lines,
                  input ready);
  modport sink   (input valid, mode, chip, port_sel, write_data, request_lines,
                  output ready);
endinterface

interface cic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       int_pending;
  logic [7:0] vector;
  logic       vector_valid;

  modport source (output valid, read_data, int_pending, vector, vector_valid,
                  input ready);
  modport sink   (input valid, read_data, int_pending, vector, vector_valid,
                  output ready);
endinterface

// ===== rtl/core/cascaded_interrupt_controller_unit.sv =====
// Master/slave pair of 8259A-style interrupt controllers, slave cascaded on
// master line 2. Each item samples all sixteen request lines and performs one
// bus read, bus write or interrupt acknowledge; its result (read data, master
// interrupt output, vector) is registered once the accepted item leaves the
// input register. One item is taken every cycle unless the result stalls: an
// input register feeds request latching, priority resolution and register
// update for both chips, which writes the result register. The input side
// keeps accepting while the result register holds as long as the held item
// can move on; a stalled result stalls input after one more item.
module cascaded_interrupt_controller_unit (
  input logic clk,
  input logic rst_n,
  cic_in_if.sink    in_ch,
  cic_out_if.source out_ch
);

  logic        in_valid_r;
  logic [1:0]  mode_r;
  logic        chip_r;
  logic        port_r;
  logic [7:0]  data_r;
  logic [15:0] req_r;

  logic        out_valid_r;
  logic [7:0]  rd_data_r;
  logic        int_r;
  logic [7:0]  vector_r;
  logic        vv_r;

  logic in_valid_nxt, out_valid_nxt;
  logic advance, accept, ack;

  cic_pkg::cic_op_t   op_m, op_s;
  cic_pkg::cic_stat_t st_m, st_s;
  logic [7:0]         lines_m;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;
  assign ack          = advance && (mode_r == cic_pkg::MODE_ACK);

  always_comb begin
    op_s.en    = advance;
    op_s.wr    = advance && (mode_r == cic_pkg::MODE_WRITE) && chip_r;
    op_s.port  = port_r;
    op_s.data  = data_r;
    op_s.grant = ack && st_m.cas_hit;

    op_m.en    = advance;
    op_m.wr    = advance && (mode_r == cic_pkg::MODE_WRITE) && !chip_r;
    op_m.port  = port_r;
    op_m.data  = data_r;
    op_m.grant = ack;

    lines_m = req_r[7:0];
    lines_m[cic_pkg::CASCADE_LINE] = req_r[cic_pkg::CASCADE_LINE] | st_s.int_s;
  end

  cic_chip u_slave (
    .clk   (clk),
    .rst_n (rst_n),
    .lines (req_r[15:8]),
    .op    (op_s),
    .stat  (st_s)
  );

  cic_chip u_master (
    .clk   (clk),
    .rst_n (rst_n),
    .lines (lines_m),
    .op    (op_m),
    .stat  (st_m)
  );

  always_comb begin
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_ch.mode;
      chip_r <= in_ch.chip;
      port_r <= in_ch.port_sel;
      data_r <= in_ch.write_data;
      req_r  <= in_ch.request_lines;
    end
    if (advance) begin
      if (mode_r == cic_pkg::MODE_READ) begin
        rd_data_r <= chip_r ? st_s.rd_data : st_m.rd_data;
      end else begin
        rd_data_r <= '0;
      end
      int_r    <= st_m.int_after;
      vector_r <= ack ? (st_m.cas_hit ? st_s.vector : st_m.vector) : 8'd0;
      vv_r     <= ack;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = rd_data_r;
  assign out_ch.int_pending  = int_r;
  assign out_ch.vector       = vector_r;
  assign out_ch.vector_valid = vv_r;

  // a master in its init sequence never raises the interrupt output
  a_init_no_int: assert property (@(posedge clk) disable iff (!rst_n)
    advance && st_m.init_after |=> !int_r)
    else $error("interrupt raised during master init");

  // acknowledge and read results never carry both payloads
  a_ack_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && vv_r |-> rd_data_r == 8'd0)
    else $error("read data on acknowledge result");

  // a held item that cannot move on stays held
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(req_r))
    else $error("held item lost");

  // a result only appears in the cycle after an item moved on
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result without item");

endmodule

// ===== rtl/core/cic_chip.sv =====
module cic_chip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         lines,
  input  cic_pkg::cic_op_t   op,
  output cic_pkg::cic_stat_t stat
);

  typedef struct packed {
    logic       v;
    logic [2:0] idx;
  } best_t;

  // fully nested: an in-service line blocks itself and all lower lines
  function automatic best_t find_best(input logic [7:0] live, input logic [7:0] isr);
    best_t  b;
    logic   done;
    b    = '0;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!done) begin
        if (isr[i]) begin
          done = 1'b1;
        end else if (live[i]) begin
          b.v   = 1'b1;
          b.idx = 3'(i);
          done  = 1'b1;
        end
      end
    end
    return b;
  endfunction

  logic [7:0] irr_r, isr_r, imr_r, cw_r, last_r;
  logic [4:0] base_r;
  logic [1:0] step_r;
  logic [2:0] flags_r;
  logic       rsel_r;

  logic [7:0] irr_nxt, isr_nxt, imr_nxt, cw_nxt, last_nxt;
  logic [4:0] base_nxt;
  logic [1:0] step_nxt;
  logic [2:0] flags_nxt;
  logic       rsel_nxt;

  logic [7:0] irr_s;
  best_t      best_s, best_a;

  always_comb begin
    if (flags_r[cic_pkg::FLAG_LEVEL]) begin
      irr_s = lines;
    end else begin
      irr_s = (irr_r | (lines & ~last_r)) & lines;
    end
    best_s = find_best(irr_s & ~imr_r, isr_r);

    irr_nxt   = irr_s;
    isr_nxt   = isr_r;
    imr_nxt   = imr_r;
    cw_nxt    = cw_r;
    last_nxt  = lines;
    base_nxt  = base_r;
    step_nxt  = step_r;
    flags_nxt = flags_r;
    rsel_nxt  = rsel_r;

    if (op.wr && !op.port) begin
      if ((op.data & cic_pkg::ICW1_START) != '0) begin
        irr_nxt   = '0;
        isr_nxt   = '0;
        imr_nxt   = '0;
        rsel_nxt  = 1'b0;
        flags_nxt = '0;
        flags_nxt[cic_pkg::FLAG_LEVEL] = (op.data & cic_pkg::ICW1_LTIM) != '0;
        flags_nxt[cic_pkg::FLAG_NEED4] = (op.data & cic_pkg::ICW1_NEED4) != '0;
        step_nxt  = cic_pkg::STEP_ICW2;
      end else if ((op.data & cic_pkg::OCW3_MARK) != '0) begin
        if ((op.data & cic_pkg::OCW3_RR) != '0) begin
          rsel_nxt = (op.data & cic_pkg::OCW3_RIS) != '0;
        end
      end else if ((op.data & cic_pkg::OCW2_EOI) != '0) begin
        if ((op.data & cic_pkg::OCW2_SPEC) != '0) begin
          isr_nxt = isr_r & ~(8'd1 << op.data[2:0]);
        end else begin
          // clear the lowest set bit: highest priority in service
          isr_nxt = isr_r & (isr_r - 8'd1);
        end
      end
    end else if (op.wr && op.port) begin
      case (step_r)
        cic_pkg::STEP_ICW2: begin
          base_nxt = op.data[7:3];
          step_nxt = cic_pkg::STEP_ICW3;
        end
        cic_pkg::STEP_ICW3: begin
          cw_nxt   = op.data;
          step_nxt = flags_r[cic_pkg::FLAG_NEED4] ? cic_pkg::STEP_ICW4
                                                  : cic_pkg::STEP_READY;
        end
        cic_pkg::STEP_ICW4: begin
          if ((op.data & cic_pkg::ICW4_AEOI) != '0) begin
            flags_nxt[cic_pkg::FLAG_AEOI] = 1'b1;
          end
          step_nxt = cic_pkg::STEP_READY;
        end
        default: begin
          imr_nxt = op.data;
        end
      endcase
    end else if (op.grant && best_s.v) begin
      irr_nxt[best_s.idx] = 1'b0;
      if (!flags_r[cic_pkg::FLAG_AEOI]) begin
        isr_nxt[best_s.idx] = 1'b1;
      end
    end

    best_a = find_best(irr_nxt & ~imr_nxt, isr_nxt);
  end

  always_comb begin
    stat.int_s      = (step_r == cic_pkg::STEP_READY) && best_s.v;
    stat.int_after  = (step_nxt == cic_pkg::STEP_READY) && best_a.v;
    stat.init_after = step_nxt != cic_pkg::STEP_READY;
    stat.cas_hit    = best_s.v && cw_r[best_s.idx];
    stat.rd_data    = op.port ? imr_r : (rsel_r ? isr_r : irr_s);
    stat.vector     = {base_r, best_s.v ? best_s.idx : 3'd7};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irr_r   <= '0;
      isr_r   <= '0;
      imr_r   <= '0;
      cw_r    <= '0;
      last_r  <= '0;
      base_r  <= '0;
      step_r  <= cic_pkg::STEP_READY;
      flags_r <= '0;
      rsel_r  <= 1'b0;
    end else if (op.en) begin
      irr_r   <= irr_nxt;
      isr_r   <= isr_nxt;
      imr_r   <= imr_nxt;
      cw_r    <= cw_nxt;
      last_r  <= last_nxt;
      base_r  <= base_nxt;
      step_r  <= step_nxt;
      flags_r <= flags_nxt;
      rsel_r  <= rsel_nxt;
    end
  end

endmodule

// ===== dv/cascaded_interrupt_controller_unit_test.sv =====
`timescale 1ns / 1ps

module cascaded_interrupt_controller_unit_test;
  import cic_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [1:0]  mode;
    logic        chip;
    logic        port_sel;
    logic [7:0]  write_data;
    logic [15:0] request_lines;
  } pic_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_pending;
    logic [7:0] vector;
    logic       vector_valid;
  } pic_reply_t;

  class pic_pair_scoreboard;
    logic [7:0] irr[2];
    logic [7:0] isr[2];
    logic [7:0] imr[2];
    logic [7:0] cas[2];
    logic [7:0] prev_lines[2];
    logic [4:0] base[2];
    logic [1:0] step[2];
    logic       level[2];
    logic       need4[2];
    logic       aeoi[2];
    logic       show_isr[2];
    pic_reply_t predicted_replies[$];
    int         errors;

    function new();
      for (int c = 0; c < 2; c++) begin
        irr[c] = '0;
        isr[c] = '0;
        imr[c] = '0;
        cas[c] = '0;
        prev_lines[c] = '0;
        base[c] = '0;
        step[c] = STEP_READY;
        level[c] = 1'b0;
        need4[c] = 1'b0;
        aeoi[c] = 1'b0;
        show_isr[c] = 1'b0;
      end
      errors = 0;
    endfunction

    function int outstanding();
      return predicted_replies.size();
    endfunction

    function void latch_lines(int c, logic [7:0] lines);
      if (level[c]) irr[c] = lines;
      else irr[c] = (irr[c] | (lines & ~prev_lines[c])) & lines;
      prev_lines[c] = lines;
    endfunction

    // fully nested: any in-service line at or above the candidate blocks it
    function int top_line(int c);
      logic [7:0] live;
      live = irr[c] & ~imr[c];
      for (int i = 0; i < 8; i++) begin
        if (isr[c][i]) return -1;
        if (live[i]) return i;
      end
      return -1;
    endfunction

    function logic irq_out(int c);
      return step[c] == STEP_READY && top_line(c) >= 0;
    endfunction

    function logic [7:0] grant_line(int c, int i);
      if (i < 0) return {base[c], 3'd7};
      irr[c][i] = 1'b0;
      if (!aeoi[c]) isr[c][i] = 1'b1;
      return {base[c], 3'(i)};
    endfunction

    function void command_write(int c, logic [7:0] d);
      if ((d & ICW1_START) != 0) begin
        irr[c] = '0;
        isr[c] = '0;
        imr[c] = '0;
        show_isr[c] = 1'b0;
        level[c] = (d & ICW1_LTIM) != 0;
        need4[c] = (d & ICW1_NEED4) != 0;
        aeoi[c] = 1'b0;
        step[c] = STEP_ICW2;
      end else if ((d & OCW3_MARK) != 0) begin
        if ((d & OCW3_RR) != 0) show_isr[c] = (d & OCW3_RIS) != 0;
      end else if ((d & OCW2_EOI) != 0) begin
        if ((d & OCW2_SPEC) != 0) isr[c][d[2:0]] = 1'b0;
        else isr[c] = isr[c] & (isr[c] - 8'd1);
      end
    endfunction

    function void data_write(int c, logic [7:0] d);
      case (step[c])
        STEP_ICW2: begin
          base[c] = d[7:3];
          step[c] = STEP_ICW3;
        end
        STEP_ICW3: begin
          cas[c] = d;
          step[c] = need4[c] ? STEP_ICW4 : STEP_READY;
        end
        STEP_ICW4: begin
          if ((d & ICW4_AEOI) != 0) aeoi[c] = 1'b1;
          step[c] = STEP_READY;
        end
        default: imr[c] = d;
      endcase
    endfunction

    function void apply_access(pic_access_t a);
      pic_reply_t r;
      logic [7:0] mline;
      int         c;
      int         i;
      r = '0;
      c = a.chip;
      latch_lines(1, a.request_lines[15:8]);
      mline = a.request_lines[7:0];
      if (irq_out(1)) mline[CASCADE_LINE] = 1'b1;
      latch_lines(0, mline);
      case (a.mode)
        MODE_READ: begin
          if (a.port_sel) r.read_data = imr[c];
          else r.read_data = show_isr[c] ? isr[c] : irr[c];
        end
        MODE_WRITE: begin
          if (a.port_sel) data_write(c, a.write_data);
          else command_write(c, a.write_data);
        end
        MODE_ACK: begin
          r.vector_valid = 1'b1;
          i = top_line(0);
          if (i >= 0 && cas[0][i]) begin
            void'(grant_line(0, i));
            r.vector = grant_line(1, top_line(1));
          end else begin
            r.vector = grant_line(0, i);
          end
        end
        default: ;
      endcase
      r.int_pending = irq_out(0);
      predicted_replies.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("reply mismatch: %s", msg);
      errors++;
    endtask

    task check_reply(pic_reply_t got);
      pic_reply_t want;
      if (predicted_replies.size() == 0) begin
        report_mismatch($sformatf("reply %h with nothing outstanding", got));
        return;
      end
      want = predicted_replies.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.int_pending !== want.int_pending)
        report_mismatch($sformatf("int_pending %b, want %b", got.int_pending,
                                  want.int_pending));
      if (got.vector !== want.vector)
        report_mismatch($sformatf("vector %h, want %h", got.vector, want.vector));
      if (got.vector_valid !== want.vector_valid)
        report_mismatch($sformatf("vector_valid %b, want %b", got.vector_valid,
                                  want.vector_valid));
    endtask
  endclass

  logic clk;
  logic rst_n;

  cic_in_if  in_ch ();
  cic_out_if out_ch ();

  cascaded_interrupt_controller_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pic_pair_scoreboard sb = new();

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          items_sent = 0;
  logic [15:0] line_state = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: check on handshake, then pick ready for the next edge
  initial begin
    pic_reply_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.read_data = out_ch.read_data;
        got.int_pending = out_ch.int_pending;
        got.vector = out_ch.vector;
        got.vector_valid = out_ch.vector_valid;
        sb.check_reply(got);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // each bit toggles about one item in eight, so edges keep coming
  function automatic logic [15:0] stir_lines();
    if ($urandom_range(19) == 0) line_state = 16'($urandom);
    else line_state = line_state ^ 16'($urandom & $urandom & $urandom);
    return line_state;
  endfunction

  task automatic issue_item(input logic [1:0] mode, input logic chip, input logic port,
                            input logic [7:0] data, input logic [15:0] lines);
    pic_access_t a;
    a.mode = mode;
    a.chip = chip;
    a.port_sel = port;
    a.write_data = data;
    a.request_lines = lines;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= a.mode;
    in_ch.chip <= a.chip;
    in_ch.port_sel <= a.port_sel;
    in_ch.write_data <= a.write_data;
    in_ch.request_lines <= a.request_lines;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.apply_access(a);
    items_sent++;
  endtask

  // ICW1..ICW4 with random content; now and then cut short
  task automatic init_chip(input logic c);
    logic [7:0] icw1;
    logic [7:0] icw3;
    int         cut;
    icw1 = 8'($urandom) | ICW1_START;
    icw3 = (c == 1'b0 && $urandom_range(3) != 0) ? 8'h04 : 8'($urandom);
    cut = ($urandom_range(19) == 0) ? $urandom_range(2) : 3;
    issue_item(MODE_WRITE, c, 1'b0, icw1, stir_lines());
    if (cut >= 1) issue_item(MODE_WRITE, c, 1'b1, 8'($urandom), stir_lines());
    if (cut >= 2) issue_item(MODE_WRITE, c, 1'b1, icw3, stir_lines());
    if (cut >= 3 && (icw1 & ICW1_NEED4) != 0)
      issue_item(MODE_WRITE, c, 1'b1, 8'($urandom), stir_lines());
  endtask

  task automatic run_random(input int n);
    int         stop_at;
    int         sel;
    logic [7:0] d;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 7) begin
        init_chip(1'($urandom_range(1)));
      end else if (sel < 29) begin
        issue_item(MODE_ACK, 1'($urandom), 1'($urandom), 8'($urandom), stir_lines());
      end else if (sel < 43) begin
        d = OCW2_EOI | (8'($urandom) & 8'h87);
        if ($urandom_range(1)) d = d | OCW2_SPEC;
        issue_item(MODE_WRITE, 1'($urandom), 1'b0, d, stir_lines());
      end else if (sel < 50) begin
        d = OCW3_MARK | (8'($urandom) & 8'hE7);
        issue_item(MODE_WRITE, 1'($urandom), 1'b0, d, stir_lines());
      end else if (sel < 57) begin
        issue_item(MODE_WRITE, 1'($urandom), 1'b1, 8'($urandom & $urandom & $urandom),
                   stir_lines());
      end else if (sel < 94) begin
        issue_item(MODE_READ, 1'($urandom), 1'($urandom), 8'($urandom), stir_lines());
      end else begin
        issue_item(2'($urandom_range(3)), 1'($urandom), 1'($urandom), 8'($urandom),
                   16'($urandom));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_READ;
    in_ch.chip <= 1'b0;
    in_ch.port_sel <= 1'b0;
    in_ch.write_data <= '0;
    in_ch.request_lines <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: nothing pending, acknowledge is spurious
    issue_item(MODE_READ, 1'b0, 1'b0, 8'h00, 16'h0000);
    issue_item(MODE_ACK, 1'b0, 1'b0, 8'h00, 16'h0000);
    issue_item(MODE_READ, 1'b0, 1'b1, 8'h00, 16'h0000);
    // master: edge triggered, cascade on line 2; slave: level triggered, auto-EOI
    issue_item(MODE_WRITE, 1'b0, 1'b0, ICW1_START | ICW1_NEED4, 16'h0000);
    issue_item(MODE_WRITE, 1'b0, 1'b1, 8'hF8, 16'h0000);
    issue_item(MODE_WRITE, 1'b0, 1'b1, 8'h04, 16'h0000);
    issue_item(MODE_WRITE, 1'b0, 1'b1, 8'h00, 16'h0000);
    issue_item(MODE_WRITE, 1'b1, 1'b0, ICW1_START | ICW1_LTIM | ICW1_NEED4, 16'h0000);
    issue_item(MODE_WRITE, 1'b1, 1'b1, 8'h70, 16'h0000);
    issue_item(MODE_WRITE, 1'b1, 1'b1, 8'h02, 16'h0000);
    issue_item(MODE_WRITE, 1'b1, 1'b1, ICW4_AEOI, 16'h0000);
    issue_item(MODE_READ, 1'b0, 1'b0, 8'h00, 16'h0001);
    issue_item(MODE_ACK, 1'b0, 1'b0, 8'h00, 16'h0001);
    issue_item(MODE_WRITE, 1'b0, 1'b0, OCW3_MARK | OCW3_RR | OCW3_RIS, 16'h0001);
    issue_item(MODE_READ, 1'b0, 1'b0, 8'h00, 16'h0001);
    issue_item(MODE_WRITE, 1'b0, 1'b0, OCW2_EOI, 16'h0001);
    // slave line 7 reaches the master through line 2
    issue_item(MODE_ACK, 1'b1, 1'b1, 8'h00, 16'h8000);
    issue_item(MODE_WRITE, 1'b0, 1'b0, OCW2_EOI | OCW2_SPEC | 8'h02, 16'h8000);
    issue_item(MODE_WRITE, 1'b0, 1'b1, 8'hFF, 16'h80FF);
    issue_item(MODE_READ, 1'b0, 1'b1, 8'h00, 16'h80FF);
    issue_item(MODE_NONE, 1'b1, 1'b1, 8'hFF, 16'hFFFF);
    issue_item(MODE_WRITE, 1'b1, 1'b0, 8'hFF, 16'hFFFF);
    issue_item(MODE_ACK, 1'b1, 1'b1, 8'hFF, 16'hFFFF);
    issue_item(MODE_WRITE, 1'b0, 1'b0, OCW3_MARK | OCW3_RR, 16'hFFFF);
    line_state = 16'hFFFF;

    run_random(350);
    // hold until the block has drained
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);

    src_idle_pct = 87;
    run_random(330);
    src_idle_pct = 0;
    sink_stall_pct = 87;
    run_random(330);
    src_idle_pct = 24;
    sink_stall_pct = 24;
    run_random(330);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_random(310);

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
